// ===== hw/rtl/pixel_alpha_blend_macros.svh =====
// ----------------------------------------------------------------------------
// Pixel alpha blend assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PIXEL_ALPHA_BLEND_MACROS_SVH
`define PIXEL_ALPHA_BLEND_MACROS_SVH

// same-cycle implication
`define PAB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pixel_alpha_blend: same-cycle check failed");

// next-cycle implication
`define PAB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel_alpha_blend: next-cycle check failed");

`endif

// ===== hw/rtl/pab_pkg.sv =====
// ----------------------------------------------------------------------------
// Pixel alpha blend package
// Constants, register codes and the per-channel configuration struct.
// ----------------------------------------------------------------------------
package pab_pkg;

  localparam int unsigned NUM_LANES = 6;

  localparam logic signed [18:0] WEIGHT_ONE = 19'sd65536;

  localparam logic [7:0] CHAN_MAX_888 = 8'hff;
  localparam logic [7:0] CHAN_MAX_555 = 8'h1f;

  localparam logic FMT_555 = 1'b0;
  localparam logic FMT_888 = 1'b1;

  localparam logic [1:0] REG_BLEND_WEIGHT = 2'd0;
  localparam logic [1:0] REG_OFFSET_LEVEL = 2'd1;
  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd2;

  localparam int unsigned POS_555 [NUM_LANES] = '{0, 5, 10, 16, 21, 26};

  typedef struct packed {
    logic        [17:0] weight;
    logic signed [18:0] weight_inv;
    logic signed [9:0]  offset2;
    logic        [7:0]  chan_max;
  } pab_cfg_t;

endpackage

// ===== hw/rtl/pixel_alpha_blend.sv =====
// ----------------------------------------------------------------------------
// Pixel alpha blend
// Blends a pixel word pair into one clamped word, 888 or two 555 pixels.
// ----------------------------------------------------------------------------
//  channel  signals                                   role
//  pix      pix_valid pix_stall first_word            word pair in
//           second_word last_in
//  blend    blend_valid blend_stall blended_word      blended word out
//           last_out
//  config   psel penable pwrite paddr pwdata          register access
//           prdata pready
//
//  One item per clock while pix_stall is low; operands load at the accept
//  edge, then the products, the sum and the output register follow in
//  that order.
//  rst clears valid bits and loads the register reset values.
//  A skid entry behind the output register absorbs a stall; pix_stall
//  is registered and rises only once that entry holds an item.
// ----------------------------------------------------------------------------
module pixel_alpha_blend (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        pix_valid,
  output logic        pix_stall,
  input  logic [31:0] first_word,
  input  logic [31:0] second_word,
  input  logic        last_in,
  output logic        blend_valid,
  input  logic        blend_stall,
  output logic [31:0] blended_word,
  output logic        last_out
);
  import pab_pkg::*;

  `include "pixel_alpha_blend_macros.svh"

  logic        [17:0] blend_weight;
  logic signed [8:0]  offset_level;
  logic               pixel_format;

  logic signed [8:0]  offset_555;
  pab_cfg_t           cfg;

  logic               advance;
  logic               out_take;
  logic [2:0]         stage_valid;
  logic [2:0]         stage_last;
  logic               skid_full;
  logic [31:0]        skid_word;
  logic               skid_last;

  logic [7:0]         s_chan [NUM_LANES];
  logic [7:0]         d_chan [NUM_LANES];
  logic [7:0]         chan   [NUM_LANES];
  logic [31:0]        packed_word;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= '0;
      offset_level <= '0;
      pixel_format <= FMT_888;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_BLEND_WEIGHT: blend_weight <= pwdata[17:0];
        REG_OFFSET_LEVEL: offset_level <= $signed(pwdata[8:0]);
        REG_PIXEL_FORMAT: pixel_format <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BLEND_WEIGHT: prdata = {14'd0, blend_weight};
      REG_OFFSET_LEVEL: prdata = {23'd0, offset_level};
      REG_PIXEL_FORMAT: prdata = {31'd0, pixel_format};
      default:          prdata = 32'd0;
    endcase
  end

  // truncate toward zero
  always_comb begin
    if (offset_level[8]) begin
      offset_555 = (offset_level + 9'sd7) >>> 3;
    end else begin
      offset_555 = offset_level >>> 3;
    end
  end

  always_comb begin
    cfg.weight     = blend_weight;
    cfg.weight_inv = WEIGHT_ONE - $signed({1'b0, blend_weight});
    if (pixel_format == FMT_888) begin
      cfg.offset2  = {offset_level, 1'b0};
      cfg.chan_max = CHAN_MAX_888;
    end else begin
      cfg.offset2  = {offset_555, 1'b0};
      cfg.chan_max = CHAN_MAX_555;
    end
  end

  assign advance   = !skid_full;
  assign pix_stall = skid_full;
  assign out_take  = !blend_valid || !blend_stall;

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    localparam int unsigned P5 = POS_555[k];

    if (k < 4) begin : g_wide
      always_comb begin
        if (pixel_format == FMT_888) begin
          s_chan[k] = first_word[8*k +: 8];
          d_chan[k] = second_word[8*k +: 8];
        end else begin
          s_chan[k] = {3'b000, first_word[P5 +: 5]};
          d_chan[k] = {3'b000, second_word[P5 +: 5]};
        end
      end
    end else begin : g_narrow
      assign s_chan[k] = {3'b000, first_word[P5 +: 5]};
      assign d_chan[k] = {3'b000, second_word[P5 +: 5]};
    end

    pab_lane u_lane (
      .clk    (clk),
      .en     (advance),
      .cfg    (cfg),
      .s_chan (s_chan[k]),
      .d_chan (d_chan[k]),
      .chan   (chan[k])
    );
  end

  always_comb begin
    if (pixel_format == FMT_888) begin
      packed_word = {chan[3], chan[2], chan[1], chan[0]};
    end else begin
      packed_word = {1'b0, chan[5][4:0], chan[4][4:0], chan[3][4:0],
                     1'b0, chan[2][4:0], chan[1][4:0], chan[0][4:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (advance) begin
      stage_valid <= {stage_valid[1:0], pix_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_last <= {stage_last[1:0], last_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_valid <= 1'b0;
      skid_full   <= 1'b0;
    end else if (out_take) begin
      blend_valid <= skid_full || stage_valid[2];
      skid_full   <= 1'b0;
    end else if (stage_valid[2] && !skid_full) begin
      skid_full   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_word <= packed_word;
      skid_last <= stage_last[2];
    end
    if (out_take) begin
      blended_word <= skid_full ? skid_word : packed_word;
      last_out     <= skid_full ? skid_last : stage_last[2];
    end
  end

  `PAB_ASSERT_NOW(a_skid_behind_out, skid_full, blend_valid)
  `PAB_ASSERT_NEXT(a_skid_catches, blend_valid && blend_stall && !skid_full && stage_valid[2],
                   skid_full)
  `PAB_ASSERT_NEXT(a_drain_empty, blend_valid && !blend_stall && !skid_full && !stage_valid[2],
                   !blend_valid)
  `PAB_ASSERT_NOW(a_555_pad_zero, blend_valid && pixel_format == FMT_555,
                  !blended_word[15] && !blended_word[31])

endmodule

// ===== hw/rtl/pab_lane.sv =====
// ----------------------------------------------------------------------------
// Pixel alpha blend channel lane
// Three register stages: operands, products, sum; clamp on the way out.
// ----------------------------------------------------------------------------
module pab_lane (
  input  logic              clk,
  input  logic              en,
  input  pab_pkg::pab_cfg_t cfg,
  input  logic [7:0]        s_chan,
  input  logic [7:0]        d_chan,
  output logic [7:0]        chan
);
  import pab_pkg::*;

  logic        [7:0]  s_q;
  logic        [7:0]  d_q;
  logic signed [27:0] p_first;
  logic        [25:0] p_second;
  logic signed [12:0] total;

  always_ff @(posedge clk) begin
    if (en) begin
      s_q      <= s_chan;
      d_q      <= d_chan;
      p_first  <= cfg.weight_inv * $signed({1'b0, s_q});
      p_second <= cfg.weight * d_q;
      total    <= $signed({{3{cfg.offset2[9]}}, cfg.offset2})
                + $signed({p_first[27], p_first[27:16]})
                + $signed({3'b000, p_second[25:16]});
    end
  end

  always_comb begin
    if (total[12]) begin
      chan = 8'h00;
    end else if (total > $signed({5'b00000, cfg.chan_max})) begin
      chan = cfg.chan_max;
    end else begin
      chan = total[7:0];
    end
  end

endmodule

// ===== test/pab_blend_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pixel alpha blend checker
// Tracks register writes on the config bus and predicts each blended word
// from its accepted word pair. Compares every accepted output item in order
// and counts mismatches and unexpected items.
// ----------------------------------------------------------------------------
module pab_blend_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        pix_valid,
  input  logic        pix_stall,
  input  logic [31:0] first_word,
  input  logic [31:0] second_word,
  input  logic        last_in,
  input  logic        blend_valid,
  input  logic        blend_stall,
  input  logic [31:0] blended_word,
  input  logic        last_out,
  output int          fail_count,
  output int          pending_count
);
  import pab_pkg::*;

  logic        [17:0] weight_q;
  logic signed [8:0]  offset_q;
  logic               format_q;
  logic        [31:0] blended_q [$];
  logic               last_q [$];
  int                 fails = 0;
  int                 pending = 0;

  assign fail_count    = fails;
  assign pending_count = pending;

  function automatic logic [7:0] mix_lane(logic [7:0] s, logic [7:0] d, longint off2,
                                          longint lane_max);
    longint w;
    longint t;
    w = longint'(weight_q);
    t = off2 + (((longint'(WEIGHT_ONE) - w) * longint'(s)) >>> 16)
             + ((w * longint'(d)) >>> 16);
    if (t < 0) begin
      t = 0;
    end else if (t > lane_max) begin
      t = lane_max;
    end
    return t[7:0];
  endfunction

  function automatic logic [31:0] blend_pair(logic [31:0] a, logic [31:0] b);
    logic [31:0] res;
    longint      off;
    int unsigned sh;
    res = '0;
    if (format_q == FMT_888) begin
      for (int k = 0; k < 4; k++) begin
        sh = 8 * k;
        res |= 32'(mix_lane(8'(a >> sh), 8'(b >> sh), 2 * longint'(offset_q),
                            longint'(CHAN_MAX_888))) << sh;
      end
    end else begin
      off = longint'((int'(offset_q) * 32) / 256);
      for (int k = 0; k < NUM_LANES; k++) begin
        sh = POS_555[k];
        res |= 32'(mix_lane(8'((a >> sh) & 32'(CHAN_MAX_555)),
                            8'((b >> sh) & 32'(CHAN_MAX_555)), 2 * off,
                            longint'(CHAN_MAX_555))) << sh;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    logic [31:0] exp_word;
    logic        exp_last;
    if (rst) begin
      weight_q = '0;
      offset_q = '0;
      format_q = FMT_888;
      blended_q.delete();
      last_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BLEND_WEIGHT: weight_q = pwdata[17:0];
          REG_OFFSET_LEVEL: offset_q = pwdata[8:0];
          REG_PIXEL_FORMAT: format_q = pwdata[0];
          default: ;
        endcase
      end
      if (blend_valid && !blend_stall) begin
        if (blended_q.size() == 0) begin
          $error("blended_word: unexpected item, actual %h", blended_word);
          fails++;
        end else begin
          exp_word = blended_q.pop_front();
          exp_last = last_q.pop_front();
          if (blended_word !== exp_word) begin
            $error("blended_word: expected %h, actual %h", exp_word, blended_word);
            fails++;
          end
          if (last_out !== exp_last) begin
            $error("last_out: expected %b, actual %b", exp_last, last_out);
            fails++;
          end
        end
      end
      if (pix_valid && !pix_stall) begin
        blended_q.push_back(blend_pair(first_word, second_word));
        last_q.push_back(last_in);
      end
    end
    pending = blended_q.size();
  end

endmodule

// ===== test/tb_pixel_alpha_blend.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pixel alpha blend testbench
// Drives word pairs and register settings into the blender, with random
// idle bursts on both sides, a long output hold and a full drain. The
// checker beside the block predicts and compares every output item.
// ----------------------------------------------------------------------------
module tb_pixel_alpha_blend;
  import pab_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 60;
  localparam int RAND_PHASES = 13;
  localparam int PHASE_ITEMS = 150;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        pix_valid;
  logic        pix_stall;
  logic [31:0] first_word;
  logic [31:0] second_word;
  logic        last_in;
  logic        blend_valid;
  logic        blend_stall;
  logic [31:0] blended_word;
  logic        last_out;
  int          fail_count;
  int          pending_count;

  logic        send_gaps = 1'b1;
  logic        stall_noise = 1'b1;
  logic        hold_req = 1'b0;

  always #5 clk = ~clk;

  pixel_alpha_blend dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .pix_valid    (pix_valid),
    .pix_stall    (pix_stall),
    .first_word   (first_word),
    .second_word  (second_word),
    .last_in      (last_in),
    .blend_valid  (blend_valid),
    .blend_stall  (blend_stall),
    .blended_word (blended_word),
    .last_out     (last_out)
  );

  pab_blend_checker chk (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .pix_valid     (pix_valid),
    .pix_stall     (pix_stall),
    .first_word    (first_word),
    .second_word   (second_word),
    .last_in       (last_in),
    .blend_valid   (blend_valid),
    .blend_stall   (blend_stall),
    .blended_word  (blended_word),
    .last_out      (last_out),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  function automatic logic [31:0] pick_word();
    logic [31:0] word;
    if ($urandom_range(0, 1) == 0) begin
      return $urandom;
    end
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 3))
        0: word[8*k +: 8] = 8'h00;
        1: word[8*k +: 8] = 8'hff;
        default: word[8*k +: 8] = 8'($urandom);
      endcase
    end
    return word;
  endfunction

  function automatic logic [17:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 18'd0;
      1: return WEIGHT_ONE[17:0];
      2: return 18'd131072;
      3: return 18'h3ffff;
      default: return 18'($urandom_range(0, 262143));
    endcase
  endfunction

  function automatic logic [8:0] pick_offset();
    case ($urandom_range(0, 4))
      0: return 9'h100;
      1: return 9'h0ff;
      2: return 9'h000;
      default: return 9'($urandom);
    endcase
  endfunction

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic drain();
    pix_valid = 1'b0;
    wait (pending_count == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_config(input logic [17:0] weight, input logic [8:0] offset,
                            input logic fmt);
    drain();
    apb_write(REG_BLEND_WEIGHT, {14'd0, weight});
    apb_write(REG_OFFSET_LEVEL, {23'd0, offset});
    apb_write(REG_PIXEL_FORMAT, {31'd0, fmt});
  endtask

  task automatic send_pixel(input logic [31:0] a, input logic [31:0] b, input logic l);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      pix_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    pix_valid   = 1'b1;
    first_word  = a;
    second_word = b;
    last_in     = l;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    blend_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        blend_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req    = 1'b0;
        blend_stall = 1'b0;
      end else if (stall_noise && $urandom_range(0, 5) == 0) begin
        blend_stall = 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        blend_stall = 1'b0;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    pix_valid   = 1'b0;
    first_word  = '0;
    second_word = '0;
    last_in     = 1'b0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    send_pixel(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_pixel(32'hffff_ffff, 32'hffff_ffff, 1'b1);

    set_config(WEIGHT_ONE[17:0], 9'h0ff, FMT_888);
    send_pixel(32'h0000_0000, 32'hffff_ffff, 1'b0);
    send_pixel(32'hffff_ffff, 32'h0000_0000, 1'b0);
    send_pixel(32'h8040_2010, 32'h0102_0408, 1'b1);

    set_config(18'd131072, 9'h100, FMT_888);
    send_pixel(32'h0000_0000, 32'hffff_ffff, 1'b0);
    send_pixel(32'hffff_ffff, 32'h0000_0000, 1'b0);
    send_pixel(32'hffff_ffff, 32'hffff_ffff, 1'b1);

    set_config(18'h3ffff, 9'h0ff, FMT_555);
    send_pixel(32'h0000_0000, 32'hffff_ffff, 1'b0);
    send_pixel(32'hffff_ffff, 32'h0000_0000, 1'b0);
    send_pixel(32'h7fff_7fff, 32'h0000_0000, 1'b1);

    set_config(18'd32768, 9'h1ff, FMT_555);
    send_pixel(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_pixel(32'h1234_5678, 32'h9abc_def0, 1'b1);

    set_config(18'd16384, 9'h100, FMT_555);
    send_pixel(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_pixel(32'h7c1f_03e0, 32'h03e0_7c1f, 1'b1);

    drain();
    apb_write(REG_UNUSED, $urandom);
    send_pixel(32'h8000_8000, 32'h7fff_7fff, 1'b0);
    send_pixel(32'h5555_aaaa, 32'haaaa_5555, 1'b1);

    for (int p = 0; p < RAND_PHASES; p++) begin
      set_config(pick_weight(), pick_offset(), 1'($urandom_range(0, 1)));
      if (p == RAND_PHASES - 1) begin
        send_gaps   = 1'b0;
        stall_noise = 1'b0;
      end
      if (p == 4) begin
        hold_req = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 7 && i == PHASE_ITEMS / 2) begin
          pix_valid = 1'b0;
          wait (pending_count == 0);
          @(negedge clk);
        end
        send_pixel(pick_word(), pick_word(), $urandom_range(0, 15) == 0);
      end
    end

    pix_valid = 1'b0;
    wait (pending_count == 0);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
